[hw/rtl/srms_pkg.sv]
// Shared constants, types and codes for the running mean / stddev block.
`timescale 1ns / 1ps
package srms_pkg;
  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int CHAN_BITS       = 3;
  localparam int FRAC_BITS       = 16;
  localparam int M2_BITS         = 55;
  localparam int OUT_MEAN_BITS   = 28;
  localparam int OUT_SD_BITS     = 20;
  localparam int OUT_CNT_BITS    = 16;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Shared shift-subtract unit control.
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } unit_ctl_t;
endpackage

[hw/rtl/sensor_running_mean_stddev.sv]
// Top level: per-channel Welford running mean and sample standard deviation.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: req_type[1:0], channel[4:2], sample[16:5]
//  m_axis  | out | tdata: channel_echo, mean_value, stddev_value, sample_count, status
// A read of a channel with fewer than two samples goes straight to the output; a clear
// writes the zeroed channel back first. An add runs the delta/n divide, builds the
// product from 16-bit slices of the second difference and updates m2; if it leaves two
// or more samples it then runs the m2/(n-1) divide and the square root, as does a read
// of two or more samples or a dropped add. One shared unit does both divides and the
// square root.
// Reset clears all channel statistics at once. s_axis_tready is low from
// acceptance until the result is taken; a stalled result holds.
`timescale 1ns / 1ps
module sensor_running_mean_stddev #(
  parameter int CHANNELS    = srms_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = srms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = srms_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], channel[4:2], sample[5+SAMPLE_BITS-1:5], zero pad
  input  logic [((5 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // channel_echo[2:0], mean_value[30:3], stddev_value[50:31],
  // sample_count[66:51], status[68:67], zero pad
  output logic [71:0] m_axis_tdata
);
  localparam int MEAN_BITS = SAMPLE_BITS + 16;
  localparam int SD_BITS   = SAMPLE_BITS + 8;
  localparam int M2B       = srms_pkg::M2_BITS;
  localparam int CIDX      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_DIV1 = 4'd2,
    S_DIV1W = 4'd3, S_MUL = 4'd4, S_M2 = 4'd5, S_DIV2 = 4'd6, S_DIV2W = 4'd7,
    S_SQ = 4'd8, S_SQW = 4'd9, S_OUT = 4'd10, S_WB = 4'd11;

  logic [3:0] state;
  logic [MEAN_BITS-1:0]  mean_mem [CHANNELS];
  logic [M2B-1:0]        m2_mem   [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_mem  [CHANNELS];

  logic [1:0]  req;
  logic [2:0]  chan;
  logic [SAMPLE_BITS-1:0] smp;
  logic        bad_ch;
  logic [CIDX-1:0] ci;
  logic signed [MEAN_BITS+1:0] delta, d2;
  logic [MEAN_BITS-1:0]  mean_r;
  logic [M2B-1:0]        m2_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [1:0]  status_r;
  logic [63:0] prod;
  logic [1:0]  mstep;
  logic [MEAN_BITS:0] abs_a, abs_b;
  logic [19:0] sd_r;

  srms_pkg::unit_ctl_t ctl;
  logic [63:0] u_num, u_den, u_res;
  logic        u_done;

  srms_divsqrt #(.W(64)) u_unit (
    .clk(clk), .rst(rst), .ctl(ctl), .num(u_num), .den(u_den),
    .res(u_res), .done(u_done)
  );

  logic signed [MEAN_BITS+1:0] xs;
  assign xs = $signed({2'b00, smp, 16'd0});
  assign abs_a = delta[MEAN_BITS+1] ? (MEAN_BITS+1)'(0) - delta[MEAN_BITS:0]
                                    : delta[MEAN_BITS:0];
  assign abs_b = d2[MEAN_BITS+1] ? (MEAN_BITS+1)'(0) - d2[MEAN_BITS:0] : d2[MEAN_BITS:0];

  logic [MEAN_BITS+16:0] pp;
  assign pp = (MEAN_BITS+17)'(abs_a) * (MEAN_BITS+17)'(16'(abs_b >> (16 * mstep)));

  logic [63:0] m2_sum;
  assign m2_sum = 64'(m2_r) + (prod >> 16);

  always_comb begin
    ctl = '0;
    u_num = '0;
    u_den = '0;
    unique case (state)
      S_DIV1: begin
        ctl.start = 1'b1;
        u_num = 64'(delta[MEAN_BITS+1] ? -delta : delta);
        u_den = 64'(n_r);
      end
      S_DIV2: begin
        ctl.start = 1'b1;
        u_num = 64'(m2_r);
        u_den = 64'(n_r - COUNT_BITS'(1));
      end
      S_SQ: begin
        ctl.start = 1'b1;
        ctl.is_sqrt = 1'b1;
        u_num = u_res;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign ci = CIDX'(chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        mean_mem[i] <= '0;
        m2_mem[i]   <= '0;
        cnt_mem[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          req  <= s_axis_tdata[1:0];
          chan <= s_axis_tdata[4:2];
          smp  <= s_axis_tdata[5 +: SAMPLE_BITS];
          bad_ch <= 32'(s_axis_tdata[4:2]) >= CHANNELS;
          state <= S_LOAD;
        end
        S_LOAD: begin
          mean_r <= mean_mem[ci];
          m2_r   <= m2_mem[ci];
          n_r    <= cnt_mem[ci];
          status_r <= srms_pkg::ST_OK;
          sd_r <= '0;
          if (bad_ch) begin
            mean_r <= '0; m2_r <= '0; n_r <= '0;
            state <= S_OUT;
          end else if (req == srms_pkg::REQ_CLEAR) begin
            mean_r <= '0; m2_r <= '0; n_r <= '0;
            state <= S_WB;
          end else if (req == srms_pkg::REQ_ADD) begin
            if (cnt_mem[ci] == CNT_FULL) begin
              status_r <= srms_pkg::ST_FULL;
              state <= S_DIV2;
            end else begin
              n_r <= cnt_mem[ci] + COUNT_BITS'(1);
              delta <= xs - $signed({2'b00, mean_mem[ci]});
              state <= S_DIV1;
            end
          end else state <= (cnt_mem[ci] < COUNT_BITS'(2)) ? S_OUT : S_DIV2;
        end
        S_DIV1: state <= S_DIV1W;
        S_DIV1W: if (u_done) begin
          // truncate toward zero: apply the sign after the magnitude divide
          logic signed [MEAN_BITS+1:0] q, mn;
          q = delta[MEAN_BITS+1] ? -(MEAN_BITS+2)'(u_res) : (MEAN_BITS+2)'(u_res);
          mn = $signed({2'b00, mean_r}) + q;
          mean_r <= mn[MEAN_BITS-1:0];
          d2 <= xs - mn;
          prod <= '0;
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod + (64'(pp) << (16 * mstep));
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= S_M2;
        end
        S_M2: begin
          m2_r <= (m2_sum > 64'({M2B{1'b1}})) ? '1 : m2_sum[M2B-1:0];
          state <= (n_r < COUNT_BITS'(2)) ? S_WB : S_DIV2;
        end
        S_DIV2: state <= (n_r < COUNT_BITS'(2)) ? S_WB : S_DIV2W;
        S_DIV2W: if (u_done) state <= S_SQ;
        S_SQ: state <= S_SQW;
        S_SQW: if (u_done) begin
          sd_r <= (u_res > 64'({SD_BITS{1'b1}})) ? 20'({SD_BITS{1'b1}}) : 20'(u_res);
          state <= S_WB;
        end
        S_WB: begin
          mean_mem[ci] <= mean_r;
          m2_mem[ci]   <= m2_r;
          cnt_mem[ci]  <= n_r;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {3'd0,
              (status_r != srms_pkg::ST_FULL && n_r < COUNT_BITS'(2))
                ? srms_pkg::ST_FEW : status_r,
              16'(n_r), sd_r, 28'(mean_r), chan};
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/srms_divsqrt.sv]
// Shared radix-2 unit: restoring divide or integer square root, one bit a cycle.
`timescale 1ns / 1ps
module srms_divsqrt #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  srms_pkg::unit_ctl_t ctl,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output logic [W-1:0]        res,
  output logic                done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   quo;
  logic [W-1:0]   rem_sh;
  logic [W+1:0]   prem;
  logic [W-1:0]   dden;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           sq;
  logic [W+1:0]   trial;
  logic [W+1:0]   cand;
  logic [W+1:0]   sub;

  always_comb begin
    if (sq) begin
      trial = {prem[W-1:0], rem_sh[W-1 -: 2]};
      cand  = {quo, 2'b01};
    end else begin
      trial = {prem[W:0], rem_sh[W-1]};
      cand  = {2'b00, dden};
    end
    sub = trial - cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        sq   <= ctl.is_sqrt;
        rem_sh <= num;
        dden <= den;
        prem <= '0;
        quo  <= '0;
        cnt  <= ctl.is_sqrt ? CW'(W / 2) : CW'(W);
      end else if (busy) begin
        // Take the difference on success, else keep the trial remainder; shift in the next bit(s).
        if (!sub[W+1]) prem <= sub;
        else prem <= trial;
        quo    <= {quo[W-2:0], ~sub[W+1]};
        rem_sh <= sq ? {rem_sh[W-3:0], 2'b00} : {rem_sh[W-2:0], 1'b0};
        cnt    <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = quo;
endmodule
